// ===== sv/ttu_pkg.sv =====
// shared types, constants and helper functions for the text to unsigned parser
`default_nettype none
package ttu_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAX_LEN   = 4096;
  localparam int POS_W     = 13;
  localparam int BASE_W    = 6;
  localparam int CH_W      = 8;
  localparam int MAC_W     = WORD_BITS + BASE_W + 1;

  localparam logic [POS_W-1:0]  MAX_POS   = POS_W'(MAX_LEN);
  localparam logic [BASE_W-1:0] NO_DIGIT  = '1;
  localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(36);
  localparam logic [BASE_W-1:0] RADIX_OCT = BASE_W'(8);
  localparam logic [BASE_W-1:0] RADIX_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0] RADIX_HEX = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_PREFIX,
    PH_AFTER0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [POS_W-1:0]     end_offset;
    logic                 overflow;
    logic                 converted;
  } result_t;

  // whitespace: space, tab, lf, vt, ff, cr
  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // digit value of a character, NO_DIGIT when it is not alphanumeric
  function automatic logic [BASE_W-1:0] char_digit(input logic [CH_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_W'(c - CH_LA) + RADIX_DEC;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_W'(c - CH_UA) + RADIX_DEC;
    end
    return d;
  endfunction

  // saturating position advance
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p);
    return (p < MAX_POS) ? p + POS_W'(1) : p;
  endfunction

endpackage
`default_nettype wire

// ===== sv/text_to_unsigned_parser.sv =====
// top level of the streaming text to unsigned integer parser
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_ch[7:0], in_first
//   out     | output    | out_valid/out_stall| out_value[31:0], out_end_offset[12:0],
//           |           |                    | out_overflow, out_converted
//   cfg     | input     | cfg_we             | cfg_base[5:0]
//
// one character per cycle sustained while no result waits on a stalled output; a result
// is presented once its stopping character is accepted (the character is captured in the
// input register, then the conversion step loads the result register once it is free)
// synchronous active-low reset clears the handshake flags, the parse state and base
// a stalled result holds in the output register while the input register still takes
// a character that produces no result; a stopping character waits until it frees
`default_nettype none
module text_to_unsigned_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [ttu_pkg::CH_W-1:0]         in_ch,
  input  wire logic                             in_first,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [ttu_pkg::WORD_BITS-1:0]    out_value,
  output      logic [ttu_pkg::POS_W-1:0]        out_end_offset,
  output      logic                             out_overflow,
  output      logic                             out_converted,
  input  wire logic                             cfg_we,
  input  wire logic [ttu_pkg::BASE_W-1:0]       cfg_base
);
  import ttu_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    step;
  logic    emit;
  logic    free;
  result_t res;
  result_t out_res;

  assign in_item.ch    = in_ch;
  assign in_item.first = in_first;

  // a character moves on unless its result has nowhere to go
  assign step = item_valid && (!emit || free);

  ttu_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .item_valid(item_valid),
    .item      (item),
    .item_take (step)
  );

  ttu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_base(cfg_base),
    .item    (item),
    .step    (step),
    .emit    (emit),
    .res     (res)
  );

  ttu_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && emit),
    .res      (res),
    .free     (free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_value      = out_res.value;
  assign out_end_offset = out_res.end_offset;
  assign out_overflow   = out_res.overflow;
  assign out_converted  = out_res.converted;

  // overflow always reports an all-ones value
  a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_value == '1)
    else $error("overflow result without all-ones value");

  // nothing converted means a zero value at offset zero
  a_noconv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_converted |-> out_value == '0 && out_end_offset == '0 && !out_overflow)
    else $error("unconverted result not zero");

  // offset never passes the saturation point
  a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_end_offset <= MAX_POS)
    else $error("end offset beyond saturation");

  // input only stalls while a character is held back by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid && emit && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// ===== sv/ttu_in_reg.sv =====
// input register stage holding one character transaction
`default_nettype none
module ttu_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire ttu_pkg::item_t in_item,
  output      logic          item_valid,
  output      ttu_pkg::item_t item,
  input  wire logic          item_take
);
  import ttu_pkg::*;

  logic  valid_r;
  item_t item_r;

  // hold while a registered item cannot move on
  assign in_stall   = valid_r && !item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ttu_core.sv =====
// parse state and the per-character step of the number conversion
`default_nettype none
module ttu_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ttu_pkg::BASE_W-1:0]   cfg_base,
  input  wire ttu_pkg::item_t               item,
  input  wire logic                         step,
  output      logic                         emit,
  output      ttu_pkg::result_t             res
);
  import ttu_pkg::*;

  logic [BASE_W-1:0]    base_r;
  phase_t               phase_r,  phase_nxt;
  logic [WORD_BITS-1:0] acc_r,    acc_nxt;
  logic [BASE_W-1:0]    radix_r,  radix_nxt;
  logic                 neg_r,    neg_nxt;
  logic                 ovf_r,    ovf_nxt;
  logic                 conv_r,   conv_nxt;
  logic [POS_W-1:0]     pos_r,    pos_nxt;
  logic                 hexp_r,   hexp_nxt;
  logic [POS_W-1:0]     zend_r,   zend_nxt;

  logic                 taken;
  logic [BASE_W-1:0]    dig;
  logic                 dig_ok;
  logic [MAC_W-1:0]     mac;

  // one character step: falls through the phases the same way a string does
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    conv_nxt  = conv_r;
    pos_nxt   = pos_r;
    hexp_nxt  = hexp_r;
    zend_nxt  = zend_r;
    taken     = 1'b0;
    emit      = 1'b0;
    res       = '0;
    dig       = char_digit(item.ch);
    dig_ok    = 1'b0;
    mac       = '0;

    // a first flag restarts the parse
    if (item.first) begin
      phase_nxt = PH_LEAD;
      acc_nxt   = '0;
      radix_nxt = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      conv_nxt  = 1'b0;
      pos_nxt   = '0;
      hexp_nxt  = 1'b0;
      zend_nxt  = '0;
    end

    // leading whitespace and one sign
    if (phase_nxt == PH_LEAD) begin
      if (is_space(item.ch)) begin
        pos_nxt = advance(pos_nxt);
        taken   = 1'b1;
      end else if (item.ch == CH_MINUS || item.ch == CH_PLUS) begin
        neg_nxt   = (item.ch == CH_MINUS);
        pos_nxt   = advance(pos_nxt);
        phase_nxt = PH_PREFIX;
        taken     = 1'b1;
      end else begin
        phase_nxt = PH_PREFIX;
      end
    end

    // leading zero in auto or hex base
    if (!taken && phase_nxt == PH_PREFIX) begin
      radix_nxt = base_r;
      if ((base_r == BASE_AUTO || base_r == RADIX_HEX) && item.ch == CH_ZERO) begin
        conv_nxt = 1'b1;
        if (base_r == BASE_AUTO) begin
          radix_nxt = RADIX_OCT;
        end
        pos_nxt   = advance(pos_nxt);
        zend_nxt  = pos_nxt;
        phase_nxt = PH_AFTER0;
        taken     = 1'b1;
      end else begin
        if (radix_nxt == BASE_AUTO) begin
          radix_nxt = RADIX_DEC;
        end
        phase_nxt = PH_DIGITS;
      end
    end

    // optional x after the zero
    if (!taken && phase_nxt == PH_AFTER0) begin
      if (item.ch == CH_LX || item.ch == CH_UX) begin
        radix_nxt = RADIX_HEX;
        hexp_nxt  = 1'b1;
        pos_nxt   = advance(pos_nxt);
        taken     = 1'b1;
      end
      phase_nxt = PH_DIGITS;
    end

    // digit accumulate, or stop and report
    if (!taken && phase_nxt == PH_DIGITS) begin
      dig_ok = (radix_nxt >= RADIX_MIN) && (radix_nxt <= RADIX_MAX) && (dig < radix_nxt);
      mac    = MAC_W'(acc_nxt) * MAC_W'(radix_nxt) + MAC_W'(dig);
      if (dig_ok) begin
        if (mac[MAC_W-1:WORD_BITS] != '0) begin
          ovf_nxt = 1'b1;
        end
        acc_nxt  = mac[WORD_BITS-1:0];
        conv_nxt = 1'b1;
        hexp_nxt = 1'b0;
        pos_nxt  = advance(pos_nxt);
      end else begin
        emit = 1'b1;
        if (ovf_nxt) begin
          res.value = '1;
        end else if (neg_nxt) begin
          res.value = '0 - acc_nxt;
        end else begin
          res.value = acc_nxt;
        end
        if (ovf_nxt) begin
          res.end_offset = pos_nxt;
        end else if (!conv_nxt) begin
          res.end_offset = '0;
        end else if (hexp_nxt) begin
          res.end_offset = zend_nxt;
        end else begin
          res.end_offset = pos_nxt;
        end
        res.overflow  = ovf_nxt;
        res.converted = conv_nxt;
        phase_nxt     = PH_DONE;
      end
    end
  end

  // base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_AUTO;
    end else if (cfg_we) begin
      base_r <= cfg_base;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      radix_r <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      conv_r  <= 1'b0;
      pos_r   <= '0;
      hexp_r  <= 1'b0;
      zend_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      conv_r  <= conv_nxt;
      pos_r   <= pos_nxt;
      hexp_r  <= hexp_nxt;
      zend_r  <= zend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ttu_out_reg.sv =====
// result register feeding the output channel
`default_nettype none
module ttu_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire ttu_pkg::result_t res,
  output      logic             free,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      ttu_pkg::result_t out_res
);
  import ttu_pkg::*;

  logic    valid_r;
  result_t res_r;

  // room for a new result when empty or when the held one leaves now
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire
